>>> design/assert_macros.svh
// Assertion macros shared by the RTL of the vector unit.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clocked check with an active-low reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check on the block clock and reset
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> design/vau_pkg.sv
// Package of the 3D vector unit: opcodes, pipeline item type, step schedule
// and the per-stage datapath function. No dependencies.
package vau_pkg;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_NEG       = 4'd2,
    OP_SCALE     = 4'd3,
    OP_DOT       = 4'd4,
    OP_CROSS     = 4'd5,
    OP_NORM      = 4'd6,
    OP_NORMALIZE = 4'd7,
    OP_ANGLE     = 4'd8
  } op_e;

  localparam int unsigned SH_STEPS     = 5;
  localparam int unsigned SQ_ITERS     = 32;
  localparam int unsigned DIV_ITERS    = 32;
  localparam int unsigned CORDIC_ITERS = 30;

  localparam int unsigned ST_MUL   = 0;
  localparam int unsigned ST_SUM   = ST_MUL + 1;
  localparam int unsigned ST_RND   = ST_SUM + 1;
  localparam int unsigned ST_SH    = ST_RND + 1;
  localparam int unsigned ST_SQA   = ST_SH + SH_STEPS;
  localparam int unsigned ST_SQAR  = ST_SQA + SQ_ITERS;
  localparam int unsigned ST_DIV   = ST_SQAR + 1;
  localparam int unsigned ST_DIT   = ST_DIV + 1;
  localparam int unsigned ST_DFIN  = ST_DIT + DIV_ITERS;
  localparam int unsigned ST_DOT   = ST_DFIN + 1;
  localparam int unsigned ST_CSUM  = ST_DOT + 1;
  localparam int unsigned ST_CSQ   = ST_CSUM + 1;
  localparam int unsigned ST_SQC   = ST_CSQ + 1;
  localparam int unsigned ST_SQCR  = ST_SQC + SQ_ITERS;
  localparam int unsigned ST_CINIT = ST_SQCR + 1;
  localparam int unsigned ST_CIT   = ST_CINIT + 1;
  localparam int unsigned ST_ANG   = ST_CIT + CORDIC_ITERS;
  localparam int unsigned N_STEPS  = ST_ANG + 1;
  localparam int unsigned N_STAGES = N_STEPS + 1;

  localparam logic [5:0]         FRAC_ANGLE  = 6'd30;
  localparam logic [5:0]         FRAC_VEC    = 6'd16;
  localparam logic [31:0]        Q_ONE       = 32'd65536;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [65:0] MAX32       = 66'sd2147483647;
  localparam logic signed [65:0] MIN32       = -66'sd2147483648;
  localparam logic signed [63:0] ONE_Q30     = 64'sd1073741824;
  localparam logic [63:0]        ONE_Q60     = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic [35:0] rem;
    logic [32:0] root;
  } sq_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] dd;
    logic [31:0] q;
  } dv_t;

  typedef struct packed {
    logic [3:0]       op;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [31:0]      s;
    logic [2:0][63:0] p1;
    logic [2:0][63:0] p2;
    logic [65:0]      t1;
    logic [65:0]      t2;
    logic [2:0][65:0] lane;
    logic             shen;
    logic             za;
    logic             zb;
    logic [63:0]      na;
    logic [63:0]      nb;
    logic [4:0]       ka;
    logic [4:0]       kb;
    sq_t              sqa;
    sq_t              sqb;
    dv_t [2:0]        dva;
    dv_t [2:0]        dvb;
    logic [31:0]      c;
    logic [33:0]      cx;
    logic [33:0]      cy;
    logic [33:0]      cz;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             flag;
  } item_t;

  typedef struct packed {
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             flag;
  } res_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > MAX32) return 32'h7FFF_FFFF;
    if (v < MIN32) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Q32.32 -> Q16.16, ties toward +inf, saturated
  function automatic logic [31:0] rsat(input logic signed [65:0] x);
    logic signed [65:0] y;
    y = (x + 66'sd32768) >>> 16;
    return sat32(y);
  endfunction

  function automatic logic signed [33:0] atan_q30(input int unsigned i);
    logic signed [33:0] one;
    one = 34'sd1;
    case (i)
      0: return 34'sd843314857;
      1: return 34'sd497837829;
      2: return 34'sd263043837;
      3: return 34'sd133525159;
      4: return 34'sd67021687;
      5: return 34'sd33543516;
      6: return 34'sd16775851;
      7: return 34'sd8388437;
      8: return 34'sd4194283;
      9: return 34'sd2097149;
      default: return one <<< (30 - i);
    endcase
  endfunction

  function automatic sq_t sq_iter(input sq_t s, input logic [1:0] bits);
    sq_t o;
    logic [35:0] r2;
    logic [35:0] trial;
    r2    = {s.rem[33:0], bits};
    trial = {1'b0, s.root, 2'b01};
    if (r2 >= trial) begin
      o.rem  = r2 - trial;
      o.root = {s.root[31:0], 1'b1};
    end else begin
      o.rem  = r2;
      o.root = {s.root[31:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sq_t sq_round(input sq_t s);
    sq_t o;
    o      = s;
    o.root = s.root + 33'(s.rem > {3'b000, s.root});
    return o;
  endfunction

  function automatic dv_t div_init(input logic [31:0] comp, input logic [5:0] sh,
                                   input logic [32:0] n);
    dv_t o;
    logic [31:0] mag;
    logic [63:0] dv;
    mag   = comp[31] ? (~comp + 32'd1) : comp;
    dv    = ({32'd0, mag} << sh) + {32'd0, n[32:1]};
    o.rem = {2'b00, dv[63:32]};
    o.dd  = dv[31:0];
    o.q   = '0;
    return o;
  endfunction

  function automatic dv_t div_iter(input dv_t d, input logic [32:0] n);
    dv_t o;
    logic [33:0] r2;
    r2 = {d.rem[32:0], d.dd[31]};
    if (r2 >= {1'b0, n}) begin
      o.rem = r2 - {1'b0, n};
      o.q   = {d.q[30:0], 1'b1};
    end else begin
      o.rem = r2;
      o.q   = {d.q[30:0], 1'b0};
    end
    o.dd = {d.dd[30:0], 1'b0};
    return o;
  endfunction

  // work done between stage k and stage k+1
  function automatic item_t vau_step(input int unsigned k, input item_t d);
    item_t o;
    int unsigned i;
    int unsigned m;
    logic [2:0][31:0] x1, y1, x2, y2;
    logic [5:0] sha, shb;
    logic signed [63:0] cs, cr, cc;
    logic signed [33:0] xs, ys, zz, at;
    o  = d;
    x1 = '0;
    y1 = '0;
    x2 = '0;
    y2 = '0;
    if (k == ST_MUL) begin
      o.r    = '0;
      o.sc   = '0;
      o.flag = 1'b0;
      case (d.op) inside
        OP_ADD: begin
          for (int j = 0; j < 3; j++)
            o.r[j] = sat32(66'($signed(d.a[j])) + 66'($signed(d.b[j])));
        end
        OP_SUB: begin
          for (int j = 0; j < 3; j++)
            o.r[j] = sat32(66'($signed(d.a[j])) - 66'($signed(d.b[j])));
        end
        OP_NEG: begin
          for (int j = 0; j < 3; j++) o.r[j] = sat32(-66'($signed(d.a[j])));
        end
        OP_SCALE: begin
          for (int j = 0; j < 3; j++) begin
            x1[j] = d.a[j];
            y1[j] = d.s;
          end
        end
        OP_DOT: begin
          for (int j = 0; j < 3; j++) begin
            x1[j] = d.a[j];
            y1[j] = d.b[j];
          end
        end
        OP_CROSS: begin
          x1[0] = d.a[1]; y1[0] = d.b[2]; x2[0] = d.a[2]; y2[0] = d.b[1];
          x1[1] = d.a[2]; y1[1] = d.b[0]; x2[1] = d.a[0]; y2[1] = d.b[2];
          x1[2] = d.a[0]; y1[2] = d.b[1]; x2[2] = d.a[1]; y2[2] = d.b[0];
        end
        OP_NORM, OP_NORMALIZE, OP_ANGLE: begin
          for (int j = 0; j < 3; j++) begin
            x1[j] = d.a[j];
            y1[j] = d.a[j];
            x2[j] = d.b[j];
            y2[j] = d.b[j];
          end
        end
        default: ;
      endcase
      for (int j = 0; j < 3; j++) begin
        o.p1[j] = $signed(x1[j]) * $signed(y1[j]);
        o.p2[j] = $signed(x2[j]) * $signed(y2[j]);
      end
    end else if (k == ST_SUM) begin
      o.t1 = 66'($signed(d.p1[0])) + 66'($signed(d.p1[1])) + 66'($signed(d.p1[2]));
      o.t2 = 66'($signed(d.p2[0])) + 66'($signed(d.p2[1])) + 66'($signed(d.p2[2]));
      for (int j = 0; j < 3; j++)
        o.lane[j] = 66'($signed(d.p1[j])) - 66'($signed(d.p2[j]));
    end else if (k == ST_RND) begin
      case (d.op) inside
        OP_SCALE, OP_CROSS: begin
          for (int j = 0; j < 3; j++) o.r[j] = rsat($signed(d.lane[j]));
        end
        OP_DOT: o.sc = rsat($signed(d.t1));
        default: ;
      endcase
      o.na   = d.t1[63:0];
      o.nb   = d.t2[63:0];
      o.za   = (d.t1[63:0] == 64'd0);
      o.zb   = (d.t2[63:0] == 64'd0);
      o.shen = (d.op != OP_NORM);
      o.ka   = '0;
      o.kb   = '0;
      o.sqa  = '0;
      o.sqb  = '0;
    end else if (k >= ST_SH && k < ST_SQA) begin
      // largest even shift that keeps the sum of squares below 2^62
      i = k - ST_SH;
      m = 16 >> i;
      if (d.shen && (d.na >> (62 - 2 * m)) == 64'd0) begin
        o.na = d.na << (2 * m);
        o.ka = d.ka + 5'(m);
      end
      if (d.shen && (d.nb >> (62 - 2 * m)) == 64'd0) begin
        o.nb = d.nb << (2 * m);
        o.kb = d.kb + 5'(m);
      end
    end else if ((k >= ST_SQA && k < ST_SQAR) || (k >= ST_SQC && k < ST_SQCR)) begin
      o.sqa = sq_iter(d.sqa, d.na[63:62]);
      o.sqb = sq_iter(d.sqb, d.nb[63:62]);
      o.na  = {d.na[61:0], 2'b00};
      o.nb  = {d.nb[61:0], 2'b00};
    end else if (k == ST_SQAR || k == ST_SQCR) begin
      o.sqa = sq_round(d.sqa);
      o.sqb = sq_round(d.sqb);
    end else if (k == ST_DIV) begin
      sha = ((d.op == OP_ANGLE) ? FRAC_ANGLE : FRAC_VEC) + {1'b0, d.ka};
      shb = FRAC_ANGLE + {1'b0, d.kb};
      for (int j = 0; j < 3; j++) begin
        o.dva[j] = div_init(d.a[j], sha, d.sqa.root);
        o.dvb[j] = div_init(d.b[j], shb, d.sqb.root);
      end
    end else if (k >= ST_DIT && k < ST_DFIN) begin
      for (int j = 0; j < 3; j++) begin
        o.dva[j] = div_iter(d.dva[j], d.sqa.root);
        o.dvb[j] = div_iter(d.dvb[j], d.sqb.root);
      end
    end else if (k == ST_DFIN) begin
      for (int j = 0; j < 3; j++) begin
        o.dva[j].q = d.a[j][31] ? (~d.dva[j].q + 32'd1) : d.dva[j].q;
        o.dvb[j].q = d.b[j][31] ? (~d.dvb[j].q + 32'd1) : d.dvb[j].q;
      end
      case (d.op) inside
        OP_NORM: begin
          o.sc = (d.sqa.root > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : d.sqa.root[31:0];
        end
        OP_NORMALIZE: begin
          if (d.za) begin
            o.r[0] = Q_ONE;
            o.r[1] = '0;
            o.r[2] = '0;
            o.flag = 1'b1;
          end else begin
            for (int j = 0; j < 3; j++) o.r[j] = o.dva[j].q;
          end
        end
        OP_ANGLE: o.flag = d.za | d.zb;
        default: ;
      endcase
    end else if (k == ST_DOT) begin
      for (int j = 0; j < 3; j++) o.p1[j] = $signed(d.dva[j].q) * $signed(d.dvb[j].q);
    end else if (k == ST_CSUM) begin
      cs = $signed(d.p1[0]) + $signed(d.p1[1]) + $signed(d.p1[2]);
      cr = (cs + 64'sd536870912) >>> 30;
      if (cr > ONE_Q30) cr = ONE_Q30;
      if (cr < -ONE_Q30) cr = -ONE_Q30;
      o.c = cr[31:0];
    end else if (k == ST_CSQ) begin
      cc    = $signed(d.c) * $signed(d.c);
      o.na  = ONE_Q60 - cc;
      o.sqa = '0;
      o.sqb = '0;
    end else if (k == ST_CINIT) begin
      if (d.c[31]) begin
        o.cx = {1'b0, d.sqa.root};
        o.cy = -34'($signed(d.c));
        o.cz = HALF_PI_Q30;
      end else begin
        o.cx = 34'($signed(d.c));
        o.cy = {1'b0, d.sqa.root};
        o.cz = '0;
      end
    end else if (k >= ST_CIT && k < ST_ANG) begin
      i  = k - ST_CIT;
      xs = $signed(d.cx) >>> i;
      ys = $signed(d.cy) >>> i;
      at = atan_q30(i);
      if (!d.cy[33]) begin
        o.cx = d.cx + ys;
        o.cy = d.cy - xs;
        o.cz = d.cz + at;
      end else begin
        o.cx = d.cx - ys;
        o.cy = d.cy + xs;
        o.cz = d.cz - at;
      end
    end else if (k == ST_ANG) begin
      zz = ($signed(d.cz) + 34'sd8192) >>> 14;
      if (d.op == OP_ANGLE) o.sc = (d.flag || zz[33]) ? 32'd0 : zz[31:0];
    end
    return o;
  endfunction

endpackage

>>> design/vector3_arith_unit.sv
// Top level of the 3D vector unit: stage pipeline plus output skid buffer.
// Depends on vau_pkg and assert_macros.svh.
//
//  channel | dir | tdata (low bit up)                          | tuser
//  s_axis  | in  | a_x a_y a_z b_x b_y b_z scale_factor (224b) | operation
//  m_axis  | out | r_x r_y r_z scalar_out (128b)               | zero_vector_flag
//
// One transfer per cycle sustained while the output is not stalled; the depth of the
// register chain is set by the 32-step square roots, the 32-step dividers and 30 CORDIC steps.
// Reset clears the stage valid bits and the output/skid valid flags only.
// A stalled output parks one result in the skid register; the pipeline then
// holds, and ready is a register output.
`include "assert_macros.svh"

module vector3_arith_unit
  import vau_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [223:0] s_axis_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scale_factor
  input  logic [3:0]   s_axis_tuser,   // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // r_x, r_y, r_z, scalar_out
  output logic [0:0]   m_axis_tuser    // zero_vector_flag
);

  item_t                  stage_q [N_STAGES];
  logic [N_STAGES-1:0]    valid_q;
  item_t                  in_item;
  res_t                   last_res, out_q, skid_q;
  logic                   out_v_q, skid_v_q;
  logic                   en, push, take;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;
  assign push          = en && valid_q[N_STAGES-1];
  assign take          = out_v_q && m_axis_tready;

  always_comb begin
    in_item      = '0;
    in_item.op   = s_axis_tuser;
    in_item.a[0] = s_axis_tdata[31:0];
    in_item.a[1] = s_axis_tdata[63:32];
    in_item.a[2] = s_axis_tdata[95:64];
    in_item.b[0] = s_axis_tdata[127:96];
    in_item.b[1] = s_axis_tdata[159:128];
    in_item.b[2] = s_axis_tdata[191:160];
    in_item.s    = s_axis_tdata[223:192];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[N_STAGES-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) stage_q[0] <= in_item;
  end

  for (genvar g = 1; g < N_STAGES; g++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en) stage_q[g] <= vau_step(g - 1, stage_q[g-1]);
    end
  end

  always_comb begin
    last_res.r    = stage_q[N_STAGES-1].r;
    last_res.sc   = stage_q[N_STAGES-1].sc;
    last_res.flag = stage_q[N_STAGES-1].flag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) skid_v_q <= 1'b0;
    end else if (push) begin
      if (out_v_q && !take) skid_v_q <= 1'b1;
      else                  out_v_q  <= 1'b1;
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) out_q <= skid_q;
    end else if (push) begin
      if (out_v_q && !take) skid_q <= last_res;
      else                  out_q  <= last_res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.sc, out_q.r[2], out_q.r[1], out_q.r[0]};
  assign m_axis_tuser  = out_q.flag;

  `ASSERT_STD(a_skid_needs_out, skid_v_q |-> out_v_q, "skid full with empty output")
  `ASSERT_STD(a_skid_fill, $rose(skid_v_q) |-> $past(out_v_q) && !$past(m_axis_tready), "skid filled without stall")
  `ASSERT_STD(a_skid_drain, (skid_v_q && m_axis_tready) |=> (out_v_q && !skid_v_q), "skid drain lost a result")

endmodule
